[hw/rtl/esop_cube_store_merge_top_macros.svh]
// Assertion macros used by the cube store top level.
`ifndef ESOP_CUBE_STORE_MERGE_TOP_MACROS_SVH
`define ESOP_CUBE_STORE_MERGE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESOPCSM_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define ESOPCSM_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

[hw/rtl/esopcsm_pkg.sv]
// Types, constants and helper functions of the ESOP cube store.
package esopcsm_pkg;

    localparam int CUBE_W   = 32;
    localparam int MAX_VARS = 32;
    localparam int VCNT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int LIT_W    = 12;
    localparam int INDEX_W  = 6;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic [CUBE_W-1:0] value;
        logic [CUBE_W-1:0] care;
    } cube_t;

    // Distance classification of a held cube against the probe cube.
    typedef struct packed {
        logic              zero;
        logic              one;
        logic [CUBE_W-1:0] diff;
    } dist_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_TAKE,
        ST_SCAN,
        ST_ERASE,
        ST_COUNT,
        ST_FINISH
    } state_t;

    // Mask of the variables in use: min(var_count, MAX_VARS, 32) low bits.
    function automatic logic [CUBE_W-1:0] var_mask(input logic [VCNT_W-1:0] vc);
        logic [6:0] n;
        logic [CUBE_W-1:0] m;
        n = 7'(vc);
        if (n > 7'(MAX_VARS)) begin
            n = 7'(MAX_VARS);
        end
        if (n >= 7'(CUBE_W)) begin
            m = '1;
        end else begin
            m = (CUBE_W'(1) << n) - CUBE_W'(1);
        end
        return m;
    endfunction

    // Population count of one word, byte counts added at the end.
    function automatic logic [5:0] pop32(input logic [CUBE_W-1:0] x);
        logic [3:0] part [4];
        logic [5:0] sum;
        for (int k = 0; k < 4; k++) begin
            part[k] = '0;
            for (int j = 0; j < 8; j++) begin
                part[k] = part[k] + {3'b000, x[8*k+j]};
            end
        end
        sum = 6'(part[0]) + 6'(part[1]) + 6'(part[2]) + 6'(part[3]);
        return sum;
    endfunction

    // Merge of a held cube with the new cube at the single differing position b.
    function automatic cube_t merge_cube(input cube_t held_c, input cube_t new_c,
                                         input logic [CUBE_W-1:0] b);
        cube_t m;
        m = held_c;
        if ((|(held_c.care & b)) && (|(new_c.care & b))) begin
            m.value = held_c.value & ~b;
            m.care  = held_c.care & ~b;
        end else if (!(|(held_c.care & b))) begin
            m.care  = held_c.care | b;
            m.value = (|(new_c.value & b)) ? (held_c.value & ~b) : (held_c.value | b);
        end else begin
            m.value = held_c.value ^ b;
        end
        return m;
    endfunction

endpackage

[hw/rtl/esopcsm_cube_unit.sv]
// Distance unit: compares one held cube with the probe cube under the variable mask.
module esopcsm_cube_unit (
    input  esopcsm_pkg::cube_t                     held,
    input  esopcsm_pkg::cube_t                     probe,
    input  logic [esopcsm_pkg::CUBE_W-1:0]         mask,
    output esopcsm_pkg::dist_t                     verdict
);

    logic [esopcsm_pkg::CUBE_W-1:0] diff;

    // A position differs when care differs or when the present literals disagree.
    assign diff = ((held.care ^ probe.care) |
                   ((held.care & held.value) ^ (probe.care & probe.value))) & mask;

    assign verdict.diff = diff;
    assign verdict.zero = (diff == '0);
    assign verdict.one  = (diff != '0) &&
                          ((diff & (diff - esopcsm_pkg::CUBE_W'(1))) == '0);

endmodule

[hw/rtl/esopcsm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module esopcsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/esop_cube_store_merge_top.sv]
// Top level of the ESOP cube store with distance-based merge.
//
// The block keeps an ordered list of up to STORE_DEPTH ESOP cubes (value word plus
// care word) in one RAM and handles one word at a time. An insert word scans the
// list through the RAM's single read port, one held cube per cycle: a held cube at
// distance 0 cancels and is erased, the first cube at distance 1 is merged with the
// new cube, erased, and the merged cube is inserted again with a fresh scan; with
// no match the cube is appended, or dropped with the overflow flag set when the
// list is full. Erasing shifts the cubes behind the erased one down by one, one
// cube per cycle. A read word returns the cube at read_index. Every word ends with
// one more pass over the list that sums the care bits in use. Each merge adds one
// more scan and erase pass, so the time a word takes is set by the single RAM read
// port and grows with occupancy. item_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next word is taken while a result
// still waits for result_ready. var_count is written through cfg_wr_en and
// cfg_wr_data and must only change while no word is in flight. The store contents
// are not cleared at reset; only entries below the held count are ever read.
`include "esop_cube_store_merge_top_macros.svh"

module esop_cube_store_merge_top #(
    parameter int STORE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic        kind,
    input  logic [31:0] cube_value,
    input  logic [31:0] cube_care,
    input  logic [5:0]  read_index,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [6:0]  count_of_cubes,
    output logic [11:0] count_of_literals,
    output logic        overflow,
    output logic [31:0] out_value,
    output logic [31:0] out_care,
    output logic        out_valid
);

    // Address width of the store, width of counts up to STORE_DEPTH, literal sum width.
    localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int LW  = $clog2(STORE_DEPTH * esopcsm_pkg::CUBE_W + 1);
    localparam int IXW = (CW > esopcsm_pkg::INDEX_W) ? CW : esopcsm_pkg::INDEX_W;

    // Control state.
    esopcsm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]       held_reg, held_next;
    logic                live_reg, live_next;
    logic [esopcsm_pkg::VCNT_W-1:0] var_count_reg;
    logic                result_valid_reg, result_valid_next;

    // Working registers.
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       lag_reg, lag_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       hit_pos_reg, hit_pos_next;
    esopcsm_pkg::cube_t  hit_cube_reg, hit_cube_next;
    logic [esopcsm_pkg::CUBE_W-1:0] hit_diff_reg, hit_diff_next;
    esopcsm_pkg::cube_t  cube_reg, cube_next;
    logic                rescan_reg, rescan_next;
    logic                ovf_reg, ovf_next;
    esopcsm_pkg::cube_t  rd_cube_reg, rd_cube_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [LW-1:0]       lit_acc_reg, lit_acc_next;

    // Output register.
    logic [esopcsm_pkg::COUNT_W-1:0] res_cubes_reg;
    logic [esopcsm_pkg::LIT_W-1:0]   res_lits_reg;
    logic                            res_ovf_reg;
    esopcsm_pkg::cube_t              res_cube_reg;
    logic                            res_ok_reg;
    logic                            res_load;

    // Store and distance unit.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    esopcsm_pkg::cube_t  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    esopcsm_pkg::cube_t  ram_rdata;
    esopcsm_pkg::dist_t  verdict;

    logic [esopcsm_pkg::CUBE_W-1:0] mask;
    logic                ptr_more;
    logic                idx_ok;
    logic                erase_done;

    assign mask     = esopcsm_pkg::var_mask(var_count_reg);
    assign ptr_more = (ptr_reg < held_reg);
    assign idx_ok   = (IXW'(read_index) < IXW'(held_reg));
    assign erase_done = (state_reg == esopcsm_pkg::ST_ERASE) && !live_reg && !ptr_more;

    esopcsm_ram #(
        .WIDTH ($bits(esopcsm_pkg::cube_t)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The held cube on the read port is always compared with the cube being inserted.
    esopcsm_cube_unit u_dist (
        .held    (ram_rdata),
        .probe   (cube_reg),
        .mask    (mask),
        .verdict (verdict)
    );

    // Sequencer. Every sweep (scan, erase, literal count) issues one RAM read per
    // cycle from ptr_reg; live_reg marks that the read data for address lag_reg is
    // on the RAM output in the current cycle.
    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        ptr_next      = ptr_reg;
        lag_next      = lag_reg;
        live_next     = live_reg;
        found_next    = found_reg;
        hit_pos_next  = hit_pos_reg;
        hit_cube_next = hit_cube_reg;
        hit_diff_next = hit_diff_reg;
        cube_next     = cube_reg;
        rescan_next   = rescan_reg;
        ovf_next      = ovf_reg;
        rd_cube_next  = rd_cube_reg;
        rd_ok_next    = rd_ok_reg;
        lit_acc_next  = lit_acc_reg;
        res_load      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = lag_reg - AW'(1);
        ram_wdata     = ram_rdata;
        ram_raddr     = ptr_reg[AW-1:0];

        case (state_reg)
            esopcsm_pkg::ST_IDLE:
            begin
                ram_raddr = AW'(read_index);
                live_next = 1'b0;
                ptr_next  = '0;
                if (item_valid)
                begin
                    // Normalize the new cube to the variables in use.
                    cube_next.care  = cube_care & mask;
                    cube_next.value = cube_value & cube_care & mask;
                    ovf_next     = 1'b0;
                    rd_ok_next   = 1'b0;
                    rd_cube_next = '0;
                    found_next   = 1'b0;
                    rescan_next  = 1'b0;
                    lit_acc_next = '0;
                    if (kind == esopcsm_pkg::KIND_READ)
                    begin
                        rd_ok_next = idx_ok;
                        state_next = esopcsm_pkg::ST_READ_TAKE;
                    end
                    else
                    begin
                        state_next = esopcsm_pkg::ST_SCAN;
                    end
                end
            end

            esopcsm_pkg::ST_READ_TAKE:
            begin
                if (rd_ok_reg)
                begin
                    rd_cube_next = ram_rdata;
                end
                ptr_next   = '0;
                live_next  = 1'b0;
                state_next = esopcsm_pkg::ST_COUNT;
            end

            esopcsm_pkg::ST_SCAN:
            begin
                if (live_reg && verdict.zero)
                begin
                    // Cancel: erase the matching cube and finish the insert.
                    ptr_next    = CW'(lag_reg) + CW'(1);
                    live_next   = 1'b0;
                    rescan_next = 1'b0;
                    state_next  = esopcsm_pkg::ST_ERASE;
                end
                else
                begin
                    if (live_reg && verdict.one && !found_reg)
                    begin
                        found_next    = 1'b1;
                        hit_pos_next  = lag_reg;
                        hit_cube_next = ram_rdata;
                        hit_diff_next = verdict.diff;
                    end
                    if (ptr_more)
                    begin
                        ptr_next  = ptr_reg + CW'(1);
                        lag_next  = ptr_reg[AW-1:0];
                        live_next = 1'b1;
                    end
                    else
                    begin
                        live_next = 1'b0;
                        if (!live_reg)
                        begin
                            if (!found_reg)
                            begin
                                if (held_reg == CW'(STORE_DEPTH))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = held_reg[AW-1:0];
                                    ram_wdata = cube_reg;
                                    held_next = held_reg + CW'(1);
                                end
                                ptr_next   = '0;
                                state_next = esopcsm_pkg::ST_COUNT;
                            end
                            else
                            begin
                                // Merge with the first distance-one cube, erase it, rescan.
                                cube_next   = esopcsm_pkg::merge_cube(hit_cube_reg, cube_reg,
                                                                      hit_diff_reg);
                                ptr_next    = CW'(hit_pos_reg) + CW'(1);
                                rescan_next = 1'b1;
                                state_next  = esopcsm_pkg::ST_ERASE;
                            end
                        end
                    end
                end
            end

            esopcsm_pkg::ST_ERASE:
            begin
                // Each cube read at lag_reg moves down to lag_reg - 1.
                if (live_reg)
                begin
                    ram_we = 1'b1;
                end
                if (ptr_more)
                begin
                    ptr_next  = ptr_reg + CW'(1);
                    lag_next  = ptr_reg[AW-1:0];
                    live_next = 1'b1;
                end
                else
                begin
                    live_next = 1'b0;
                    if (!live_reg)
                    begin
                        held_next  = held_reg - CW'(1);
                        ptr_next   = '0;
                        found_next = 1'b0;
                        state_next = rescan_reg ? esopcsm_pkg::ST_SCAN : esopcsm_pkg::ST_COUNT;
                    end
                end
            end

            esopcsm_pkg::ST_COUNT:
            begin
                if (live_reg)
                begin
                    lit_acc_next = lit_acc_reg + LW'(esopcsm_pkg::pop32(ram_rdata.care & mask));
                end
                if (ptr_more)
                begin
                    ptr_next  = ptr_reg + CW'(1);
                    lag_next  = ptr_reg[AW-1:0];
                    live_next = 1'b1;
                end
                else
                begin
                    live_next = 1'b0;
                    if (!live_reg)
                    begin
                        state_next = esopcsm_pkg::ST_FINISH;
                    end
                end
            end

            esopcsm_pkg::ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    res_load   = 1'b1;
                    state_next = esopcsm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = esopcsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= esopcsm_pkg::ST_IDLE;
            held_reg         <= '0;
            live_reg         <= 1'b0;
            var_count_reg    <= esopcsm_pkg::VCNT_W'(32);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            held_reg         <= held_next;
            live_reg         <= live_next;
            result_valid_reg <= result_valid_next;
            if (cfg_wr_en)
            begin
                var_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        lag_reg      <= lag_next;
        found_reg    <= found_next;
        hit_pos_reg  <= hit_pos_next;
        hit_cube_reg <= hit_cube_next;
        hit_diff_reg <= hit_diff_next;
        cube_reg     <= cube_next;
        rescan_reg   <= rescan_next;
        ovf_reg      <= ovf_next;
        rd_cube_reg  <= rd_cube_next;
        rd_ok_reg    <= rd_ok_next;
        lit_acc_reg  <= lit_acc_next;
        if (res_load)
        begin
            res_cubes_reg <= esopcsm_pkg::COUNT_W'(held_reg);
            res_lits_reg  <= esopcsm_pkg::LIT_W'(lit_acc_reg);
            res_ovf_reg   <= ovf_reg;
            res_cube_reg  <= rd_cube_reg;
            res_ok_reg    <= rd_ok_reg;
        end
    end

    assign item_ready        = (state_reg == esopcsm_pkg::ST_IDLE);
    assign result_valid      = result_valid_reg;
    assign count_of_cubes    = res_cubes_reg;
    assign count_of_literals = res_lits_reg;
    assign overflow          = res_ovf_reg;
    assign out_value         = res_cube_reg.value;
    assign out_care          = res_cube_reg.care;
    assign out_valid         = res_ok_reg;

    // The held count never passes the store depth.
    `ESOPCSM_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, held_reg <= CW'(STORE_DEPTH),
                        "held count above store depth")

    // Writes land only on held entries or on the append slot.
    `ESOPCSM_ASSERT_IMP(a_write_range, clk, rst_n, ram_we, CW'(ram_waddr) <= held_reg,
                        "store write beyond held entries")

    // A finished erase removes exactly one cube.
    `ESOPCSM_ASSERT_NXT(a_erase_shrinks, clk, rst_n, erase_done,
                        held_reg == $past(held_reg) - CW'(1), "erase did not remove one cube")

    // A dropped cube is only reported with a full store.
    `ESOPCSM_ASSERT_IMP(a_overflow_full, clk, rst_n, result_valid && overflow,
                        count_of_cubes == esopcsm_pkg::COUNT_W'(STORE_DEPTH),
                        "overflow with room left")

endmodule
